FILE: rtl/soc_pkg.sv
// Shared types, action codes and the double-compare helpers for the subsequence counter.
`default_nettype none

package soc_pkg;

  // Widths that the item fields fix.
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned OutWidth   = 32;

  localparam logic [ValueWidth-1:0] AbsMask = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValueWidth-1:0] ExpAll  = 64'h7FF0_0000_0000_0000;

  // Action codes carried by a request.
  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_SEQ    = 2'd2,
    ACT_NONE   = 2'd3
  } soc_action_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic                  start;
    logic                  append;
    logic                  seq;
    logic [ValueWidth-1:0] value;
  } soc_op_t;

  // A double is NaN when its exponent is all ones and its mantissa is nonzero.
  function automatic logic is_nan(input logic [ValueWidth-1:0] x);
    is_nan = (x & AbsMask) > ExpAll;
  endfunction

  // Equality as doubles: NaN never matches, and +0 equals -0.
  function automatic logic same_double(input logic [ValueWidth-1:0] a,
                                       input logic [ValueWidth-1:0] b);
    logic either_nan;
    either_nan = is_nan(a) || is_nan(b);
    same_double = !either_nan && ((a == b) || (((a | b) & AbsMask) == '0));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/soc_cell.sv
// One cell of the counting chain: a pattern element, its valid bit and its prefix count.
`default_nettype none

module soc_cell
  import soc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire soc_op_t                op_i,
  input  wire logic                   prev_valid_i,
  input  wire logic [COUNT_WIDTH-1:0] below_i,
  output logic                        valid_o,
  output logic                        valid_nxt_o,
  output logic [COUNT_WIDTH-1:0]      count_o,
  output logic [COUNT_WIDTH-1:0]      count_nxt_o,
  output logic                        sat_o
);

  logic                   valid_r;
  logic                   valid_nxt;
  logic [ValueWidth-1:0]  elem_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic                   take_elem;
  logic                   hit;
  logic [COUNT_WIDTH:0]   sum;

  // This cell is the append target when the cell before it is filled and it is not.
  assign take_elem = op_i.append && prev_valid_i && !valid_r;

  // A sequence element that matches a filled cell adds the neighbor's old count.
  assign hit = op_i.seq && valid_r && same_double(op_i.value, elem_r);
  assign sum = {1'b0, count_r} + {1'b0, below_i};

  always_comb begin
    valid_nxt = valid_r;
    if (op_i.start) begin
      valid_nxt = 1'b0;
    end else if (take_elem) begin
      valid_nxt = 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (op_i.start || op_i.append) begin
      count_nxt = '0;
    end else if (hit) begin
      count_nxt = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  // Pattern element storage.
  always_ff @(posedge clk) begin
    if (take_elem && !op_i.start) begin
      elem_r <= op_i.value;
    end
  end

  assign valid_o     = valid_r;
  assign valid_nxt_o = valid_nxt;
  assign count_o     = count_r;
  assign count_nxt_o = count_nxt;
  assign sat_o       = hit && sum[COUNT_WIDTH];

endmodule

`default_nettype wire

FILE: rtl/subsequence_occurrence_counter_unit.sv
// Top level of the subsequence counter: the cell chain, the flags and the result register.
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_ready, in_action, in_value | request in
//   out     | out_valid, out_ready, out_occurrences,  | result out
//           | out_count_saturated, out_pattern_overflow|
//
// One request is taken per cycle unless the output stalls; its result appears in the output register on the next cycle.
// All cells compare and add in parallel within that cycle, so the rate is one request per cycle.
// A request is taken while the output register is empty or being drained in the same cycle.
// Synchronous reset empties the pattern, clears all counts and both flags.
// An unused action code is taken and gives no result.
`default_nettype none

module subsequence_occurrence_counter_unit
  import soc_pkg::*;
#(
  parameter int unsigned PATTERN_DEPTH = 16,
  parameter int unsigned COUNT_WIDTH   = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_action,
  input  wire logic [ValueWidth-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OutWidth-1:0]        out_occurrences,
  output logic                       out_count_saturated,
  output logic                       out_pattern_overflow
);

  localparam int unsigned WideWidth = (COUNT_WIDTH > OutWidth) ? COUNT_WIDTH : OutWidth;

  logic                   accept;
  soc_action_t            action;
  soc_op_t                op;
  logic [PATTERN_DEPTH:0] prev_valid;
  logic [PATTERN_DEPTH-1:0] valid_q;
  logic [PATTERN_DEPTH:0] valid_n;
  logic [PATTERN_DEPTH-1:0] sat_hit;
  logic [COUNT_WIDTH-1:0] count_q [PATTERN_DEPTH];
  logic [COUNT_WIDTH-1:0] count_n [PATTERN_DEPTH];
  logic [COUNT_WIDTH-1:0] total;
  logic [WideWidth-1:0]   total_wide;
  logic                   sat_r, sat_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OutWidth-1:0]    occ_r;
  logic                   out_sat_r;
  logic                   out_ovf_r;

  // Handshake and decode of the request.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign action   = soc_action_t'(in_action);

  always_comb begin
    op.start  = 1'b0;
    op.append = 1'b0;
    op.seq    = 1'b0;
    op.value  = in_value;
    if (accept) begin
      unique case (action)
        ACT_START:  op.start  = 1'b1;
        ACT_APPEND: op.append = 1'b1;
        ACT_SEQ:    op.seq    = 1'b1;
        default:    ;
      endcase
    end
  end

  // The chain: each cell sees the valid bit and old count of the cell before it.
  assign prev_valid[0] = 1'b1;
  assign valid_n[PATTERN_DEPTH] = 1'b0;

  for (genvar j = 0; j < PATTERN_DEPTH; j++) begin : g_cell
    logic [COUNT_WIDTH-1:0] below;
    if (j == 0) begin : g_first
      assign below = COUNT_WIDTH'(1);
    end else begin : g_rest
      assign below = count_q[j-1];
    end
    assign prev_valid[j+1] = valid_q[j];

    soc_cell #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op_i        (op),
      .prev_valid_i(prev_valid[j]),
      .below_i     (below),
      .valid_o     (valid_q[j]),
      .valid_nxt_o (valid_n[j]),
      .count_o     (count_q[j]),
      .count_nxt_o (count_n[j]),
      .sat_o       (sat_hit[j])
    );
  end

  // The running total is the count of the last filled cell, or one for an empty pattern.
  always_comb begin
    total = '0;
    for (int j = 0; j < PATTERN_DEPTH; j++) begin
      if (valid_n[j] && !valid_n[j+1]) begin
        total = total | count_n[j];
      end
    end
    if (!valid_n[0]) begin
      total = COUNT_WIDTH'(1);
    end
  end

  assign total_wide = WideWidth'(total);

  // Sticky flags, cleared by a start request.
  always_comb begin
    sat_nxt = sat_r | (|sat_hit);
    ovf_nxt = ovf_r | (op.append && valid_q[PATTERN_DEPTH-1]);
    if (op.start) begin
      sat_nxt = 1'b0;
      ovf_nxt = 1'b0;
    end
  end

  // The output register fills on a meaningful request and empties when taken.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (op.start || op.append || op.seq) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sat_r       <= sat_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, clamped to the output width.
  always_ff @(posedge clk) begin
    if (op.start || op.append || op.seq) begin
      occ_r     <= (total_wide > WideWidth'({OutWidth{1'b1}})) ? {OutWidth{1'b1}}
                                                               : total_wide[OutWidth-1:0];
      out_sat_r <= sat_nxt;
      out_ovf_r <= ovf_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_occurrences      = occ_r;
  assign out_count_saturated  = out_sat_r;
  assign out_pattern_overflow = out_ovf_r;

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the subsequence occurrence counter with a built-in predictor.
module tb_top;
  import soc_pkg::*;

  localparam int unsigned PatternDepth = 16;
  localparam int unsigned CountWidth   = 32;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned RandomTarget = 430;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned HoldAfter    = 150;
  localparam int unsigned DrainCycles  = 10;

  localparam logic [63:0] PosZero = 64'h0000_0000_0000_0000;
  localparam logic [63:0] NegZero = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PosInf  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NegInf  = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] QuietNan = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    soc_action_t action;
    logic [63:0] value;
  } request_t;

  typedef struct {
    logic [OutWidth-1:0] occurrences;
    logic                saturated;
    logic                overflow;
  } tally_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = ACT_NONE;
  logic [63:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OutWidth-1:0] out_occurrences;
  logic out_count_saturated;
  logic out_pattern_overflow;

  request_t pending_requests[$];
  tally_t   expected_tallies[$];
  int unsigned planned_results = 0;
  int unsigned accepted_requests = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_cycles = 0;

  // Predictor state: the pattern, the row of prefix counts and both flags.
  logic [63:0]           pattern_elems[PatternDepth];
  int unsigned           pattern_len = 0;
  logic [CountWidth-1:0] prefix_row[PatternDepth];
  logic                  sat_seen = 1'b0;
  logic                  ovf_seen = 1'b0;

  subsequence_occurrence_counter_unit #(
    .PATTERN_DEPTH(PatternDepth),
    .COUNT_WIDTH  (CountWidth)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_occurrences     (out_occurrences),
    .out_count_saturated (out_count_saturated),
    .out_pattern_overflow(out_pattern_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Two doubles match unless either is NaN; signed zeros match each other.
  function automatic logic doubles_match(input logic [63:0] a, input logic [63:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
    b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
    if (a_nan || b_nan) return 1'b0;
    return (a == b) || ((a[62:0] == '0) && (b[62:0] == '0));
  endfunction

  // Advance the predictor by one accepted request and queue the tally it yields.
  task automatic predict_tally(input soc_action_t action, input logic [63:0] value);
    logic [CountWidth:0] sum;
    logic [CountWidth-1:0] below;
    tally_t t;
    int j;
    case (action)
      ACT_START: begin
        pattern_len = 0;
        sat_seen = 1'b0;
        ovf_seen = 1'b0;
        for (j = 0; j < PatternDepth; j++) prefix_row[j] = '0;
      end
      ACT_APPEND: begin
        if (pattern_len >= PatternDepth) begin
          ovf_seen = 1'b1;
        end else begin
          pattern_elems[pattern_len] = value;
          pattern_len++;
        end
        // A new pattern element restarts the counting from here on.
        for (j = 0; j < PatternDepth; j++) prefix_row[j] = '0;
      end
      ACT_SEQ: begin
        // Walk from the longest prefix down so each cell sees the old row.
        for (j = pattern_len; j >= 1; j--) begin
          if (doubles_match(value, pattern_elems[j-1])) begin
            below = (j == 1) ? CountWidth'(1) : prefix_row[j-2];
            sum = {1'b0, prefix_row[j-1]} + {1'b0, below};
            if (sum[CountWidth]) begin
              prefix_row[j-1] = '1;
              sat_seen = 1'b1;
            end else begin
              prefix_row[j-1] = sum[CountWidth-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (action != ACT_NONE) begin
      t.occurrences = (pattern_len == 0) ? OutWidth'(1) : OutWidth'(prefix_row[pattern_len-1]);
      t.saturated = sat_seen;
      t.overflow = ovf_seen;
      expected_tallies.push_back(t);
    end
  endtask

  // Mostly back-to-back, sometimes short gaps, rarely long ones; some stretches never idle.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (cycle_count[8:7] == 2'b01) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Request driver.
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_tally(soc_action_t'(in_action), in_value);
        accepted_requests <= accepted_requests + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_requests.size() != 0) begin
          req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_action <= req.action;
          in_value <= req.value;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off that backs up the block.
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin
    int unsigned g;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_requests >= HoldAfter) begin
      out_ready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      g = pick_gap();
      out_ready <= (g == 0);
      if (g != 0) stall_left <= g - 1;
    end
  end

  // Result monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    tally_t t;
    int unsigned errs;
    errs = 0;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tallies.size() == 0) begin
        $error("unexpected result: occurrences=%0d", out_occurrences);
        errs++;
      end else begin
        t = expected_tallies.pop_front();
        if (out_occurrences !== t.occurrences) begin
          $error("occurrences: expected %0d, got %0d", t.occurrences, out_occurrences);
          errs++;
        end
        if (out_count_saturated !== t.saturated) begin
          $error("count_saturated: expected %0b, got %0b", t.saturated, out_count_saturated);
          errs++;
        end
        if (out_pattern_overflow !== t.overflow) begin
          $error("pattern_overflow: expected %0b, got %0b", t.overflow, out_pattern_overflow);
          errs++;
        end
      end
      if (errs != 0) mismatches <= mismatches + errs;
    end
  end

  // Watchdog on cycles where neither channel moves.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic add_request(input soc_action_t action, input logic [63:0] value);
    request_t req;
    req.action = action;
    req.value = value;
    pending_requests.push_back(req);
    if (action != ACT_NONE) planned_results++;
  endtask

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Symbols that stress the double compare: signed zeros, infinity, NaNs, random bits.
  function automatic logic [63:0] pick_symbol();
    logic [51:0] mant;
    logic sign;
    sign = 1'($urandom_range(0, 1));
    mant = 52'(random_word());
    if (mant == '0) mant = 52'd1;
    case ($urandom_range(0, 9))
      0: return PosZero;
      1: return NegZero;
      2: return {sign, PosInf[62:0]};
      3: return {sign, 11'h7FF, mant};
      4: return AllOnes;
      default: return random_word();
    endcase
  endfunction

  // A zero goes out with a random sign so both encodings meet each other.
  function automatic logic [63:0] with_any_zero_sign(input logic [63:0] v);
    logic sign;
    sign = 1'($urandom_range(0, 1));
    if (v[62:0] == '0) return {sign, 63'd0};
    return v;
  endfunction

  // One random problem: a start, a pattern, then a sequence with occasional noise.
  task automatic add_problem();
    logic [63:0] alphabet[3];
    logic [63:0] sym;
    int unsigned kind;
    int unsigned plen;
    int unsigned slen;
    int unsigned i;
    int unsigned r;
    for (i = 0; i < 3; i++) alphabet[i] = pick_symbol();
    add_request(ACT_START, random_word());
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // Repeated symbol on a full pattern drives the counts into saturation.
      sym = ($urandom_range(0, 1) != 0) ? PosZero : random_word();
      if (sym[62:52] == 11'h7FF) sym[62] = 1'b0;
      for (i = 0; i < PatternDepth; i++) add_request(ACT_APPEND, with_any_zero_sign(sym));
      slen = $urandom_range(36, 42);
      for (i = 0; i < slen; i++) add_request(ACT_SEQ, with_any_zero_sign(sym));
      if ($urandom_range(0, 1) != 0) begin
        add_request(ACT_APPEND, with_any_zero_sign(sym));
        add_request(ACT_SEQ, with_any_zero_sign(sym));
      end
      return;
    end
    if (kind < 20) plen = $urandom_range(PatternDepth - 1, PatternDepth + 3);
    else if (kind < 24) plen = 0;
    else plen = $urandom_range(1, 6);
    for (i = 0; i < plen; i++)
      add_request(ACT_APPEND, with_any_zero_sign(alphabet[$urandom_range(0, 2)]));
    slen = $urandom_range(4, 20);
    for (i = 0; i < slen; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) add_request(ACT_NONE, random_word());
      else if (r < 8) add_request(ACT_APPEND, with_any_zero_sign(alphabet[$urandom_range(0, 2)]));
      else if (r < 20) add_request(ACT_SEQ, pick_symbol());
      else add_request(ACT_SEQ, with_any_zero_sign(alphabet[$urandom_range(0, 2)]));
    end
  endtask

  initial begin
    int unsigned directed_results;
    for (int k = 0; k < PatternDepth; k++) begin
      pattern_elems[k] = '0;
      prefix_row[k] = '0;
    end

    // Directed requests: empty pattern, unused code, signed zeros, NaN, infinities.
    add_request(ACT_SEQ, random_word());
    add_request(ACT_NONE, random_word());
    add_request(ACT_APPEND, PosZero);
    add_request(ACT_SEQ, NegZero);
    add_request(ACT_SEQ, PosZero);
    add_request(ACT_SEQ, QuietNan);
    add_request(ACT_APPEND, QuietNan);
    add_request(ACT_SEQ, NegZero);
    add_request(ACT_SEQ, QuietNan);
    add_request(ACT_START, AllOnes);
    add_request(ACT_APPEND, AllOnes);
    add_request(ACT_SEQ, AllOnes);
    add_request(ACT_START, PosZero);
    add_request(ACT_APPEND, 64'h0000_0000_0000_0001);
    add_request(ACT_APPEND, PosInf);
    add_request(ACT_SEQ, 64'h0000_0000_0000_0001);
    add_request(ACT_SEQ, PosInf);
    add_request(ACT_SEQ, NegInf);
    add_request(ACT_NONE, PosZero);
    add_request(ACT_SEQ, PosInf);
    add_request(ACT_SEQ, NegZero);
    directed_results = planned_results;

    while (planned_results < directed_results + RandomTarget) add_problem();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
